FILE: src/umc_pkg.sv
package umc_pkg;

  // Field widths of the input item and the result item.
  localparam int unsigned TS_W     = 48;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned MS_W     = 10;

  // First instant that no longer fits a four-digit year.
  localparam logic [TS_W-1:0] LIMIT_MS = 48'd253402300800000;

  // Day count comes from (ts >> 10) / 84375, since 86400000 = 1024 * 84375.
  localparam int unsigned       DAYS_W    = 22;
  localparam int unsigned       REM_W     = 17;
  localparam logic [REM_W-1:0]  DAY_DIV   = 17'd84375;

  // 38-bit dividend (19-bit halves) times 39-bit reciprocal (20/19-bit parts),
  // so each partial product stays small. Exact for every 48-bit timestamp.
  localparam int unsigned       DIV_STAGES = 5;
  localparam int unsigned       K_DAY      = 55;
  localparam logic [38:0]       RCP_DAY    = 39'(((64'd1 << K_DAY) / 64'd84375) + 64'd1);
  localparam logic [19:0]       RCP_DAY_HI = RCP_DAY[38:19];
  localparam logic [18:0]       RCP_DAY_LO = RCP_DAY[18:0];

  // Date pipeline constants.
  localparam int unsigned       Z_W           = 23;
  localparam int unsigned       ERA_W         = 6;
  localparam int unsigned       DOE_W         = 18;
  localparam int unsigned       YOE_W         = 9;
  localparam int unsigned       DOY_W         = 9;
  localparam int unsigned       MP_W          = 4;
  localparam logic [Z_W-1:0]    DAYS_TO_EPOCH = 23'd719468;
  localparam logic [Z_W-1:0]    ERA_DAYS      = 23'd146097;
  localparam logic [DOE_W-1:0]  ERA_LAST_DAY  = 18'd146096;

  // Reciprocals for division by a constant: q = (x * RCP) >> K, exact over
  // the operand range in use.
  localparam int unsigned      K_ERA    = 40;
  localparam logic [22:0]      RCP_ERA  = 23'(((64'd1 << K_ERA) / 64'd146097) + 64'd1);
  localparam int unsigned      K_1460   = 29;
  localparam logic [18:0]      RCP_1460 = 19'(((64'd1 << K_1460) / 64'd1460) + 64'd1);
  localparam int unsigned      K_36524  = 34;
  localparam logic [18:0]      RCP_36524 = 19'(((64'd1 << K_36524) / 64'd36524) + 64'd1);
  localparam int unsigned      K_365    = 27;
  localparam logic [18:0]      RCP_365  = 19'(((64'd1 << K_365) / 64'd365) + 64'd1);
  localparam int unsigned      K_100    = 16;
  localparam logic [9:0]       RCP_100  = 10'(((64'd1 << K_100) / 64'd100) + 64'd1);
  localparam int unsigned      K_153    = 19;
  localparam logic [11:0]      RCP_153  = 12'(((64'd1 << K_153) / 64'd153) + 64'd1);

  // Time of day constants.
  localparam int unsigned      SOD_W    = 17;
  localparam int unsigned      REMH_W   = 12;
  localparam int unsigned      K_125    = 31;
  localparam logic [24:0]      RCP_125  = 25'(((64'd1 << K_125) / 64'd125) + 64'd1);
  localparam int unsigned      K_3600   = 29;
  localparam logic [17:0]      RCP_3600 = 18'(((64'd1 << K_3600) / 64'd3600) + 64'd1);
  localparam int unsigned      K_60     = 20;
  localparam logic [14:0]      RCP_60   = 15'(((64'd1 << K_60) / 64'd60) + 64'd1);

  // Pipeline depths.
  localparam int unsigned DATE_STAGES  = 9;
  localparam int unsigned TOD_CORE     = 5;
  localparam int unsigned TOD_PAD      = DATE_STAGES - TOD_CORE;
  localparam int unsigned PIPE_LATENCY = DIV_STAGES + DATE_STAGES + 1;

  typedef struct packed {
    logic valid;
    logic oor;
  } umc_ctl_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } umc_date_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [MS_W-1:0]     millisecond;
  } umc_tod_t;

  // Day of the March-based year on which month index mp begins.
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

FILE: src/umc_day_div.sv
module umc_day_div
  import umc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TS_W-1:0]   ts,
  output umc_ctl_t          ctl,
  output logic [DAYS_W-1:0] days,
  output logic [REM_W-1:0]  rem,
  output logic [MS_W-1:0]   ms_lo
);

  logic            valid_r [DIV_STAGES];
  logic            oor_r   [DIV_STAGES];
  logic [MS_W-1:0] ms_lo_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      valid_r[0] <= start;
      for (int i = 1; i < DIV_STAGES; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    oor_r[0]   <= (ts >= LIMIT_MS);
    ms_lo_r[0] <= ts[MS_W-1:0];
    for (int i = 1; i < DIV_STAGES; i++) begin
      oor_r[i]   <= oor_r[i-1];
      ms_lo_r[i] <= ms_lo_r[i-1];
    end
  end

  // Stage 0: the dividend is ts >> 10.
  logic [37:0] s0_x_r;
  always_ff @(posedge clk) begin
    s0_x_r <= ts[TS_W-1:MS_W];
  end

  // Stage 1: four partial products of the dividend and the reciprocal.
  logic [38:0]      s1_hh_r;
  logic [37:0]      s1_hl_r;
  logic [38:0]      s1_lh_r;
  logic [37:0]      s1_ll_r;
  logic [REM_W-1:0] s1_xlo_r;
  always_ff @(posedge clk) begin
    s1_hh_r  <= 39'(s0_x_r[37:19]) * 39'(RCP_DAY_HI);
    s1_hl_r  <= 38'(s0_x_r[37:19]) * 38'(RCP_DAY_LO);
    s1_lh_r  <= 39'(s0_x_r[18:0]) * 39'(RCP_DAY_HI);
    s1_ll_r  <= 38'(s0_x_r[18:0]) * 38'(RCP_DAY_LO);
    s1_xlo_r <= s0_x_r[REM_W-1:0];
  end

  // Stage 2: middle column; the low 19 bits of the low product never carry.
  logic [38:0]      s2_hh_r;
  logic [40:0]      s2_mid_r;
  logic [REM_W-1:0] s2_xlo_r;
  always_ff @(posedge clk) begin
    s2_hh_r  <= s1_hh_r;
    s2_mid_r <= 41'(s1_hl_r) + 41'(s1_lh_r) + 41'(s1_ll_r[37:19]);
    s2_xlo_r <= s1_xlo_r;
  end

  // Stage 3: day count is the product shifted right by 55 = 19 + 19 + 17.
  logic [39:0]       sum_hi;
  logic [DAYS_W-1:0] s3_q_r;
  logic [REM_W-1:0]  s3_xlo_r;
  assign sum_hi = 40'(s2_hh_r) + 40'(s2_mid_r[40:19]);
  always_ff @(posedge clk) begin
    s3_q_r   <= DAYS_W'(sum_hi >> 17);
    s3_xlo_r <= s2_xlo_r;
  end

  // Stage 4: the remainder is below 2^17, so the low bits alone give it.
  logic [DAYS_W-1:0] s4_q_r;
  logic [REM_W-1:0]  s4_rem_r;
  always_ff @(posedge clk) begin
    s4_q_r   <= s3_q_r;
    s4_rem_r <= s3_xlo_r - s3_q_r[REM_W-1:0] * DAY_DIV;
  end

  assign ctl.valid = valid_r[DIV_STAGES-1];
  assign ctl.oor   = oor_r[DIV_STAGES-1];
  assign days      = s4_q_r;
  assign rem       = s4_rem_r;
  assign ms_lo     = ms_lo_r[DIV_STAGES-1];

endmodule

FILE: src/umc_date.sv
module umc_date
  import umc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  umc_ctl_t          ctl_in,
  input  logic [DAYS_W-1:0] days,
  output umc_ctl_t          ctl_out,
  output umc_date_t         date
);

  umc_ctl_t ctl_r [DATE_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DATE_STAGES; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[0] <= ctl_in;
      for (int i = 1; i < DATE_STAGES; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // Stage 1: shift the day count to start on 0000-03-01.
  logic [Z_W-1:0] s1_z_r;
  always_ff @(posedge clk) begin
    s1_z_r <= Z_W'(days) + DAYS_TO_EPOCH;
  end

  // Stage 2: 400-year era.
  logic [45:0]      era_prod;
  logic [Z_W-1:0]   s2_z_r;
  logic [ERA_W-1:0] s2_era_r;
  assign era_prod = 46'(s1_z_r) * 46'(RCP_ERA);
  always_ff @(posedge clk) begin
    s2_z_r   <= s1_z_r;
    s2_era_r <= era_prod[K_ERA +: ERA_W];
  end

  // Stage 3: day of era.
  logic [Z_W-1:0]   era_base;
  logic [DOE_W-1:0] s3_doe_r;
  logic [ERA_W-1:0] s3_era_r;
  assign era_base = Z_W'(s2_era_r) * ERA_DAYS;
  always_ff @(posedge clk) begin
    s3_doe_r <= DOE_W'(s2_z_r - era_base);
    s3_era_r <= s2_era_r;
  end

  // Stage 4: remove the leap days so that a plain divide by 365 gives the year.
  logic [36:0]      q1460_prod;
  logic [36:0]      q36524_prod;
  logic [DOE_W-1:0] q1460;
  logic [DOE_W-1:0] q36524;
  logic [DOE_W-1:0] s4_adj_r;
  logic [DOE_W-1:0] s4_doe_r;
  logic [ERA_W-1:0] s4_era_r;
  assign q1460_prod  = 37'(s3_doe_r) * 37'(RCP_1460);
  assign q36524_prod = 37'(s3_doe_r) * 37'(RCP_36524);
  assign q1460       = DOE_W'(q1460_prod >> K_1460);
  assign q36524      = DOE_W'(q36524_prod >> K_36524);
  always_ff @(posedge clk) begin
    s4_adj_r <= s3_doe_r - q1460 + q36524
                - DOE_W'(s3_doe_r == ERA_LAST_DAY);
    s4_doe_r <= s3_doe_r;
    s4_era_r <= s3_era_r;
  end

  // Stage 5: year of era.
  logic [36:0]      yoe_prod;
  logic [YOE_W-1:0] s5_yoe_r;
  logic [DOE_W-1:0] s5_doe_r;
  logic [ERA_W-1:0] s5_era_r;
  assign yoe_prod = 37'(s4_adj_r) * 37'(RCP_365);
  always_ff @(posedge clk) begin
    s5_yoe_r <= YOE_W'(yoe_prod >> K_365);
    s5_doe_r <= s4_doe_r;
    s5_era_r <= s4_era_r;
  end

  // Stage 6: days before this year of the era, less the century correction.
  logic [18:0]      c100_prod;
  logic [YOE_W-1:0] s6_c100_r;
  logic [DOE_W-1:0] s6_ydays_r;
  logic [YOE_W-1:0] s6_yoe_r;
  logic [DOE_W-1:0] s6_doe_r;
  logic [ERA_W-1:0] s6_era_r;
  assign c100_prod = 19'(s5_yoe_r) * 19'(RCP_100);
  always_ff @(posedge clk) begin
    s6_c100_r  <= YOE_W'(c100_prod >> K_100);
    s6_ydays_r <= DOE_W'(s5_yoe_r) * DOE_W'(365) + DOE_W'(s5_yoe_r >> 2);
    s6_yoe_r   <= s5_yoe_r;
    s6_doe_r   <= s5_doe_r;
    s6_era_r   <= s5_era_r;
  end

  // Stage 7: day of the March-based year.
  logic [DOY_W-1:0] s7_doy_r;
  logic [YOE_W-1:0] s7_yoe_r;
  logic [ERA_W-1:0] s7_era_r;
  always_ff @(posedge clk) begin
    s7_doy_r <= DOY_W'(s6_doe_r - s6_ydays_r + DOE_W'(s6_c100_r));
    s7_yoe_r <= s6_yoe_r;
    s7_era_r <= s6_era_r;
  end

  // Stage 8: month index counted from March.
  logic [11:0]      mp_num;
  logic [22:0]      mp_prod;
  logic [MP_W-1:0]  s8_mp_r;
  logic [DOY_W-1:0] s8_doy_r;
  logic [YOE_W-1:0] s8_yoe_r;
  logic [ERA_W-1:0] s8_era_r;
  assign mp_num  = 12'(s7_doy_r) * 12'd5 + 12'd2;
  assign mp_prod = 23'(mp_num) * 23'(RCP_153);
  always_ff @(posedge clk) begin
    s8_mp_r  <= MP_W'(mp_prod >> K_153);
    s8_doy_r <= s7_doy_r;
    s8_yoe_r <= s7_yoe_r;
    s8_era_r <= s7_era_r;
  end

  // Stage 9: calendar fields; January and February belong to the next year.
  logic [MONTH_W-1:0] mon;
  umc_date_t          date_r;
  assign mon = (s8_mp_r < 4'd10) ? MONTH_W'(s8_mp_r + 4'd3) : MONTH_W'(s8_mp_r - 4'd9);
  always_ff @(posedge clk) begin
    date_r.day   <= DAY_W'(s8_doy_r - month_start(s8_mp_r) + 9'd1);
    date_r.month <= mon;
    date_r.year  <= YEAR_W'(s8_yoe_r) + YEAR_W'(s8_era_r) * YEAR_W'(400)
                    + YEAR_W'(mon <= 4'd2);
  end

  assign ctl_out = ctl_r[DATE_STAGES-1];
  assign date    = date_r;

endmodule

FILE: src/umc_tod.sv
module umc_tod
  import umc_pkg::*;
(
  input  logic             clk,
  input  logic [REM_W-1:0] rem,
  input  logic [MS_W-1:0]  ms_lo,
  output umc_tod_t         tod
);

  // Stage 1: seconds of day. The millisecond of day is {rem, ms_lo}, so its
  // eighth is {rem, ms_lo[9:3]}, and that divided by 125 is the second count.
  logic [23:0]      eighth;
  logic [48:0]      sod_prod;
  logic [SOD_W-1:0] s1_sod_r;
  logic [MS_W-1:0]  s1_ms_lo_r;
  assign eighth   = {rem, ms_lo[MS_W-1:3]};
  assign sod_prod = 49'(eighth) * 49'(RCP_125);
  always_ff @(posedge clk) begin
    s1_sod_r   <= SOD_W'(sod_prod >> K_125);
    s1_ms_lo_r <= ms_lo;
  end

  // Stage 2: millisecond remainder and hour.
  logic [MS_W-1:0]   sec_ms;
  logic [34:0]       hour_prod;
  logic [SOD_W-1:0]  s2_sod_r;
  logic [MS_W-1:0]   s2_ms_r;
  logic [HOUR_W-1:0] s2_hour_r;
  assign sec_ms    = MS_W'(s1_sod_r * SOD_W'(1000));
  assign hour_prod = 35'(s1_sod_r) * 35'(RCP_3600);
  always_ff @(posedge clk) begin
    s2_sod_r  <= s1_sod_r;
    s2_ms_r   <= s1_ms_lo_r - sec_ms;
    s2_hour_r <= HOUR_W'(hour_prod >> K_3600);
  end

  // Stage 3: seconds within the hour.
  logic [REMH_W-1:0] s3_remh_r;
  logic [MS_W-1:0]   s3_ms_r;
  logic [HOUR_W-1:0] s3_hour_r;
  always_ff @(posedge clk) begin
    s3_remh_r <= REMH_W'(s2_sod_r - SOD_W'(s2_hour_r) * SOD_W'(3600));
    s3_ms_r   <= s2_ms_r;
    s3_hour_r <= s2_hour_r;
  end

  // Stage 4: minute.
  logic [26:0]         min_prod;
  logic [REMH_W-1:0]   s4_remh_r;
  logic [MINUTE_W-1:0] s4_min_r;
  logic [MS_W-1:0]     s4_ms_r;
  logic [HOUR_W-1:0]   s4_hour_r;
  assign min_prod = 27'(s3_remh_r) * 27'(RCP_60);
  always_ff @(posedge clk) begin
    s4_remh_r <= s3_remh_r;
    s4_min_r  <= MINUTE_W'(min_prod >> K_60);
    s4_ms_r   <= s3_ms_r;
    s4_hour_r <= s3_hour_r;
  end

  // Stage 5: second, then a delay line to line up with the date pipeline.
  umc_tod_t pad_r [TOD_PAD+1];
  always_ff @(posedge clk) begin
    pad_r[0].hour        <= s4_hour_r;
    pad_r[0].minute      <= s4_min_r;
    pad_r[0].second      <= SECOND_W'(s4_remh_r - REMH_W'(s4_min_r) * REMH_W'(60));
    pad_r[0].millisecond <= s4_ms_r;
    for (int i = 1; i <= TOD_PAD; i++) begin
      pad_r[i] <= pad_r[i-1];
    end
  end

  assign tod = pad_r[TOD_PAD];

endmodule

FILE: src/unix_ms_to_utc_calendar.sv
// Throughput: one timestamp per cycle; busy is always low and the result path
// never stalls. Depth is set by the 5-stage day-count unit (input register,
// partial products, two adds, remainder), the 9-stage date pipeline and one
// output register. Reset (rst_n low, synchronous) clears every valid bit; no
// strobe follows for timestamps taken before reset.
module unix_ms_to_utc_calendar
  import umc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [TS_W-1:0]     in_timestamp_ms,
  output logic                out_valid,
  output logic [DAY_W-1:0]    out_day_of_month,
  output logic [MONTH_W-1:0]  out_month,
  output logic [YEAR_W-1:0]   out_year,
  output logic [HOUR_W-1:0]   out_hour,
  output logic [MINUTE_W-1:0] out_minute,
  output logic [SECOND_W-1:0] out_second,
  output logic [MS_W-1:0]     out_millisecond,
  output logic                out_out_of_range
);

  umc_ctl_t          div_ctl;
  logic [DAYS_W-1:0] div_days;
  logic [REM_W-1:0]  div_rem;
  logic [MS_W-1:0]   div_ms_lo;
  umc_ctl_t          date_ctl;
  umc_date_t         date;
  umc_tod_t          tod;

  assign busy = 1'b0;

  umc_day_div u_day_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ts    (in_timestamp_ms),
    .ctl   (div_ctl),
    .days  (div_days),
    .rem   (div_rem),
    .ms_lo (div_ms_lo)
  );

  umc_date u_date (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (div_ctl),
    .days    (div_days),
    .ctl_out (date_ctl),
    .date    (date)
  );

  umc_tod u_tod (
    .clk   (clk),
    .rem   (div_rem),
    .ms_lo (div_ms_lo),
    .tod   (tod)
  );

  logic                out_valid_r;
  logic [DAY_W-1:0]    day_r;
  logic [MONTH_W-1:0]  month_r;
  logic [YEAR_W-1:0]   year_r;
  logic [HOUR_W-1:0]   hour_r;
  logic [MINUTE_W-1:0] minute_r;
  logic [SECOND_W-1:0] second_r;
  logic [MS_W-1:0]     ms_r;
  logic                oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= date_ctl.valid;
    end
  end

  // Past year 9999 every field but the flag reads zero.
  always_ff @(posedge clk) begin
    oor_r <= date_ctl.oor;
    if (date_ctl.oor) begin
      day_r    <= '0;
      month_r  <= '0;
      year_r   <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      ms_r     <= '0;
    end else begin
      day_r    <= date.day;
      month_r  <= date.month;
      year_r   <= date.year;
      hour_r   <= tod.hour;
      minute_r <= tod.minute;
      second_r <= tod.second;
      ms_r     <= tod.millisecond;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_day_of_month = day_r;
  assign out_month        = month_r;
  assign out_year         = year_r;
  assign out_hour         = hour_r;
  assign out_minute       = minute_r;
  assign out_second       = second_r;
  assign out_millisecond  = ms_r;
  assign out_out_of_range = oor_r;

`ifndef NO_ASSERTIONS
  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid)
    else $error("accepted beat did not produce a result strobe");

  a_no_beat_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##PIPE_LATENCY !out_valid)
    else $error("result strobe without an accepted beat");

  a_range_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_day_of_month == '0 && out_month == '0 && out_year == '0 &&
       out_hour == '0 && out_minute == '0 && out_second == '0 &&
       out_millisecond == '0))
    else $error("out-of-range result carries nonzero fields");

  a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range) |->
      (out_month >= 4'd1 && out_month <= 4'd12 && out_day_of_month >= 5'd1 &&
       out_year >= 14'd1970 && out_hour <= 5'd23 && out_minute <= 6'd59 &&
       out_second <= 6'd59 && out_millisecond <= 10'd999))
    else $error("calendar field outside its legal range");
`endif

endmodule
